// ----- rtl/wrmc_pkg.sv -----
// shared types, constants and a helper function of the windowed rms current meter
// no dependencies
package wrmc_pkg;

  localparam int unsigned MaxSamples  = 4096;
  localparam int unsigned FullScaleMv = 3300;
  localparam int unsigned AdcMax      = 4095;

  localparam int unsigned RawW    = 12;
  localparam int unsigned MvW     = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned SumW    = 24;
  localparam int unsigned SqSumW  = 36;
  localparam int unsigned NumW    = 48;
  localparam int unsigned DivW    = 52;
  localparam int unsigned RootW   = 26;
  localparam int unsigned OffW    = 20;
  localparam int unsigned SmoothW = 24;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned AlphaW  = 9;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [CfgAddrW-1:0] {
    REG_CURRENT_GAIN  = 3'd0,
    REG_OVERLOAD_MA   = 3'd1,
    REG_NOISE_FLOOR   = 3'd2,
    REG_OFFSET_ALPHA  = 3'd3,
    REG_SMOOTH_ALPHA  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_NUM,
    DIV_VAR,
    DIV_MEAN,
    DIV_CHK
  } div_sel_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CONV, S_ACC, S_LAST, S_MUL1, S_MUL2, S_NUM,
    S_DIVN, S_WDIVN, S_DIVV, S_WDIVV, S_SQRT, S_WSQRT, S_AMP,
    S_DIVM, S_WDIVM, S_DIVC, S_WDIVC, S_EMA1, S_EMA2, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     conv;
    logic     acc;
    logic     clear;
    logic     mul1;
    logic     mul2;
    logic     num;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     amp;
    logic     cap_mean;
    logic     cap_chk;
    logic     ema1;
    logic     ema2;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic n_lt2;
    logic div_done;
    logic sqrt_done;
    logic out_busy;
  } dp_status_t;

  // raw * full scale / 4095, exact: x = 4095*q0 + (q0 + low12)
  function automatic logic [MvW-1:0] to_mv(input logic [RawW-1:0] raw);
    logic [23:0] x;
    logic [11:0] q0;
    logic [12:0] r;
    logic [11:0] q;
    x  = raw * 24'(FullScaleMv);
    q0 = x[23:12];
    r  = {1'b0, x[11:0]} + {1'b0, q0};
    q  = q0 + ((r >= 13'(AdcMax)) ? 12'd1 : 12'd0);
    return q;
  endfunction

endpackage

// ----- rtl/wrmc_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on wrmc_pkg
module wrmc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wrmc_pkg::DivW-1:0]   dividend_i,
  input  logic [wrmc_pkg::CountW-1:0] divisor_i,
  output logic [wrmc_pkg::DivW-1:0]   quotient_o,
  output logic                        done_o
);
  import wrmc_pkg::*;

  logic [DivW-1:0]   dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CountW:0]   sh;
  logic              ge;

  always_comb begin
    sh     = {rem_q, dvd_q[DivW-1]};
    ge     = sh >= {1'b0, divisor_i};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? CountW'(sh - {1'b0, divisor_i}) : CountW'(sh);
      dvd_d = {dvd_q[DivW-2:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;
endmodule

// ----- rtl/wrmc_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
// depends on wrmc_pkg
module wrmc_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wrmc_pkg::DivW-1:0]  value_i,
  output logic [wrmc_pkg::RootW-1:0] root_o,
  output logic                       done_o
);
  import wrmc_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic [DivW-1:0]  val_q, val_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW+1:0]  sh;
  logic [RemW+1:0]  trial;
  logic             ge;

  always_comb begin
    sh     = {rem_q, val_q[DivW-1:DivW-2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = sh >= trial;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? RemW'(sh - trial) : RemW'(sh);
      root_d = {root_q[RootW-2:0], ge};
      val_d  = {val_q[DivW-3:0], 2'b00};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;
endmodule

// ----- rtl/wrmc_datapath.sv -----
// accumulators, window-end arithmetic, ema state, config and output registers
// depends on wrmc_pkg, wrmc_div, wrmc_sqrt
module wrmc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wrmc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [wrmc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [wrmc_pkg::InDataW-1:0]  in_data_i,
  input  logic                          in_good_i,
  input  logic                          in_last_i,
  input  wrmc_pkg::dp_cmd_t             cmd_i,
  output wrmc_pkg::dp_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wrmc_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_overload_o
);
  import wrmc_pkg::*;

  logic [15:0] gain_q, limit_q, floor_q;
  logic [AlphaW-1:0] off_alpha_q, sm_alpha_q;

  logic [RawW-1:0] raw_cur_q, raw_chk_q;
  logic good_q, last_q;
  logic [MvW-1:0] mv_cur_q, mv_chk_q;

  logic [CountW-1:0] n_q;
  logic [SumW-1:0]   sum_q, chk_sum_q;
  logic [SqSumW-1:0] sq_sum_q;

  logic [30:0] p_lo_q, p_hi_q;
  logic [NumW-1:0] sq_q, num_q;
  logic [41:0] amp_raw_q;
  logic [OffW-1:0] mean_q;
  logic [MvW-1:0]  chk_q;
  logic [28:0] off_p1_q, off_p2_q;
  logic [32:0] sm_p1_q, sm_p2_q;
  logic over_q;
  logic [OffW-1:0]    off_est_q;
  logic [SmoothW-1:0] smooth_q;

  logic [DivW-1:0] div_dvd, div_quot;
  logic div_done;
  logic [RootW-1:0] root;
  logic sqrt_done;

  logic out_valid_q;
  logic [15:0] out_cur_q;
  logic [MvW-1:0] out_chk_q, out_dc_q;
  logic [CountW-1:0] out_n_q;
  logic out_over_q;

  logic [SmoothW-1:0] amp_q8, amp_nf;
  logic [AlphaW-1:0] a_off, a_sm;
  logic [29:0] off_sum;
  logic [33:0] sm_sum;
  logic [16:0] cur_round;
  logic [12:0] dc_round;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= 16'd1024;
      limit_q     <= 16'd2500;
      floor_q     <= 16'd50;
      off_alpha_q <= AlphaW'(26);
      sm_alpha_q  <= AlphaW'(77);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CURRENT_GAIN: gain_q      <= cfg_data_i;
        REG_OVERLOAD_MA:  limit_q     <= cfg_data_i;
        REG_NOISE_FLOOR:  floor_q     <= cfg_data_i;
        REG_OFFSET_ALPHA: off_alpha_q <= cfg_data_i[AlphaW-1:0];
        REG_SMOOTH_ALPHA: sm_alpha_q  <= cfg_data_i[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_NUM:  div_dvd = {4'd0, num_q};
      DIV_VAR:  div_dvd = {div_quot[SqSumW-1:0], 16'd0};
      DIV_MEAN: div_dvd = {20'd0, sum_q, 8'd0};
      DIV_CHK:  div_dvd = {28'd0, chk_sum_q};
      default:  div_dvd = '0;
    endcase
  end

  wrmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (n_q),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  wrmc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (div_quot),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_cur_q <= in_data_i[RawW-1:0];
      raw_chk_q <= in_data_i[2*RawW-1:RawW];
      good_q    <= in_good_i;
      last_q    <= in_last_i;
    end
    if (cmd_i.conv) begin
      mv_cur_q <= to_mv(raw_cur_q);
      mv_chk_q <= to_mv(raw_chk_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      sum_q     <= '0;
      sq_sum_q  <= '0;
      chk_sum_q <= '0;
    end else if (cmd_i.clear) begin
      n_q       <= '0;
      sum_q     <= '0;
      sq_sum_q  <= '0;
      chk_sum_q <= '0;
    end else if (cmd_i.acc && good_q && (n_q < CountW'(MaxSamples))) begin
      n_q       <= n_q + 1'b1;
      sum_q     <= sum_q + SumW'(mv_cur_q);
      sq_sum_q  <= sq_sum_q + SqSumW'(mv_cur_q * mv_cur_q);
      chk_sum_q <= chk_sum_q + SumW'(mv_chk_q);
    end
  end

  // window-end arithmetic
  always_comb begin
    amp_q8  = (amp_raw_q[41:8] > 34'hFFFFFF) ? 24'hFFFFFF : amp_raw_q[31:8];
    amp_nf  = (amp_q8 < {floor_q, 8'd0}) ? '0 : amp_q8;
    a_off   = (off_alpha_q > 9'd256) ? 9'd256 : off_alpha_q;
    a_sm    = (sm_alpha_q > 9'd256) ? 9'd256 : sm_alpha_q;
    off_sum = 30'(off_p1_q) + 30'(off_p2_q) + 30'd128;
    sm_sum  = 34'(sm_p1_q) + 34'(sm_p2_q) + 34'd128;
    cur_round = 17'(({1'b0, smooth_q} + 25'd128) >> 8);
    dc_round  = 13'(({1'b0, off_est_q} + 21'd128) >> 8);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p_lo_q <= n_q * sq_sum_q[17:0];
      sq_q   <= sum_q * sum_q;
    end
    if (cmd_i.mul2) p_hi_q <= n_q * sq_sum_q[35:18];
    if (cmd_i.num)  num_q  <= NumW'({p_hi_q, 18'd0} + 49'(p_lo_q) - 49'(sq_q));
    if (cmd_i.amp)  amp_raw_q <= root * gain_q;
    if (cmd_i.cap_mean) mean_q <= (div_quot > 52'hFFFFF) ? 20'hFFFFF : div_quot[OffW-1:0];
    if (cmd_i.cap_chk)  chk_q  <= (div_quot > 52'hFFF) ? 12'hFFF : div_quot[MvW-1:0];
    if (cmd_i.ema1) begin
      off_p1_q <= a_off * mean_q;
      off_p2_q <= (9'd256 - a_off) * off_est_q;
      sm_p1_q  <= a_sm * amp_nf;
      sm_p2_q  <= (9'd256 - a_sm) * smooth_q;
      over_q   <= amp_q8 > {limit_q, 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_est_q <= '0;
      smooth_q  <= '0;
    end else if (cmd_i.ema2) begin
      off_est_q <= off_sum[OffW+7:8];
      smooth_q  <= sm_sum[SmoothW+7:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cur_q  <= cur_round[16] ? 16'hFFFF : cur_round[15:0];
      out_chk_q  <= chk_q;
      out_dc_q   <= dc_round[12] ? 12'hFFF : dc_round[11:0];
      out_n_q    <= n_q;
      out_over_q <= over_q;
    end
  end

  assign status_o.last      = last_q;
  assign status_o.n_lt2     = n_q < CountW'(2);
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = {3'd0, out_n_q, out_dc_q, out_chk_q, out_cur_q};
  assign out_overload_o = out_over_q;
endmodule

// ----- rtl/wrmc_ctrl.sv -----
// sequencing state machine of the meter
// depends on wrmc_pkg
module wrmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wrmc_pkg::dp_status_t status_i,
  output wrmc_pkg::dp_cmd_t    cmd_o
);
  import wrmc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CONV;
      S_CONV:  state_d = S_ACC;
      S_ACC:   state_d = status_i.last ? S_LAST : S_IDLE;
      S_LAST:  state_d = status_i.n_lt2 ? S_IDLE : S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_NUM;
      S_NUM:   state_d = S_DIVN;
      S_DIVN:  state_d = S_WDIVN;
      S_WDIVN: if (status_i.div_done) state_d = S_DIVV;
      S_DIVV:  state_d = S_WDIVV;
      S_WDIVV: if (status_i.div_done) state_d = S_SQRT;
      S_SQRT:  state_d = S_WSQRT;
      S_WSQRT: if (status_i.sqrt_done) state_d = S_AMP;
      S_AMP:   state_d = S_DIVM;
      S_DIVM:  state_d = S_WDIVM;
      S_WDIVM: if (status_i.div_done) state_d = S_DIVC;
      S_DIVC:  state_d = S_WDIVC;
      S_WDIVC: if (status_i.div_done) state_d = S_EMA1;
      S_EMA1:  state_d = S_EMA2;
      S_EMA2:  state_d = S_OUT;
      S_OUT:   if (!status_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_NUM;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CONV: cmd_o.conv = 1'b1;
      S_ACC:  cmd_o.acc  = 1'b1;
      S_LAST: cmd_o.clear = status_i.n_lt2;
      S_MUL1: cmd_o.mul1 = 1'b1;
      S_MUL2: cmd_o.mul2 = 1'b1;
      S_NUM:  cmd_o.num  = 1'b1;
      S_DIVN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_NUM;
      end
      S_DIVV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_VAR;
      end
      S_SQRT: cmd_o.sqrt_start = 1'b1;
      S_AMP:  cmd_o.amp = 1'b1;
      S_DIVM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
      end
      S_DIVC: begin
        cmd_o.cap_mean  = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_CHK;
      end
      S_EMA1: begin
        cmd_o.cap_chk = 1'b1;
        cmd_o.ema1    = 1'b1;
      end
      S_EMA2: cmd_o.ema2 = 1'b1;
      S_OUT: begin
        cmd_o.out_load = !status_i.out_busy;
        cmd_o.clear    = !status_i.out_busy;
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/windowed_rms_current_meter.sv -----
// Windowed AC RMS current meter: each request is loaded, converted and accumulated before
// the next one is taken while a window is open; the request that closes a window with two or
// more good samples starts the window-end sequence, which runs four passes of the shared
// bit-serial divider and one pass of the bit-serial square root unit;
// a result request is held in an output register until taken.
// depends on wrmc_pkg, wrmc_ctrl, wrmc_datapath
module windowed_rms_current_meter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wrmc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [wrmc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wrmc_pkg::InDataW-1:0]  s_axis_tdata,   // raw_current, raw_check
  input  logic                          s_axis_tuser,   // sample_good
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wrmc_pkg::OutDataW-1:0] m_axis_tdata,   // current_ma, check_mv, dc_offset_mv, sample_count
  output logic                          m_axis_tuser    // overload
);
  import wrmc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wrmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wrmc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_data_i      (s_axis_tdata),
    .in_good_i      (s_axis_tuser),
    .in_last_i      (s_axis_tlast),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_overload_o (m_axis_tuser)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  a_count_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[52:40] >= 13'd2)
    else $error("result from a short window");

  a_mv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:28] <= 12'(FullScaleMv))
                   && (m_axis_tdata[27:16] <= 12'(FullScaleMv)))
    else $error("millivolt result above full scale");
endmodule
